### sv/refcounted_page_free_list_allocator_defines.svh
// Assertion macros shared by the page allocator RTL.
`ifndef REFCOUNTED_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpfl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpfl: next-cycle check failed");

`endif

### sv/rpfl_pkg.sv
// Shared constants and types of the page allocator.
`timescale 1ns / 1ps
`default_nettype none

package rpfl_pkg;

  // Geometry of managed memory.
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;

  // Field and storage widths.
  localparam int ADDR_W   = 40;
  localparam int WIDE_W   = ADDR_W + 2;
  localparam int IDX_W    = $clog2(NUM_PAGES);
  localparam int CNT_W    = $clog2(NUM_PAGES + 1);
  localparam int QIDX_W   = WIDE_W - PAGE_SHIFT;
  localparam int REF_W    = 16;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  // Configuration port.
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 64;
  localparam int CFG_SEL_BIT = 3;

  // Derived constants.
  localparam logic [WIDE_W-1:0] SPAN      = WIDE_W'(NUM_PAGES) << PAGE_SHIFT;
  localparam logic [WIDE_W-1:0] PAGE_MASK = (WIDE_W'(1) << PAGE_SHIFT) - WIDE_W'(1);
  localparam logic [REF_W-1:0]  REF_MAX   = '1;
  localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(64'h8000_0000);
  localparam logic [ADDR_W-1:0] KEND_RESET = ADDR_W'(64'h8000_0000);
  localparam logic [CNT_W-1:0]  STACK_FULL = CNT_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_PAGES - 1);

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_INCREF = 2'd2,
    REQ_INIT   = 2'd3
  } req_kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_PAGE  = 2'd1,
    STS_BAD_ADDR = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_t;

  // Configuration register selects.
  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_KEND = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

### sv/rpfl_ifs.sv
// Request and result channel interfaces of the page allocator.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: kind of request and page address.
interface rpfl_req_if import rpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, output req_type, output page_address, input ready);
  modport sink   (input valid, input req_type, input page_address, output ready);
endinterface

// Result channel: one result for each request.
interface rpfl_rsp_if import rpfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   alloc_address;
  logic                page_freed;
  logic [REF_W-1:0]    ref_count;

  modport source (output valid, output status, output alloc_address, output page_freed,
                  output ref_count, input ready);
  modport sink   (input valid, input status, input alloc_address, input page_freed,
                  input ref_count, output ready);
endinterface

`default_nettype wire

### sv/refcounted_page_free_list_allocator.sv
// Reference-counted page allocator: a LIFO free stack and a per-page count memory.
//
// The block keeps a stack of free page indices and a 16-bit reference count per
// page, each in a single-port synchronous memory inside this module. For alloc,
// free and incref the accept cycle issues the memory read; the S_EXEC state then,
// once the result register is free, modifies, writes back and loads the result
// register, and a new request is only accepted once that result is loaded.
// Init walks the pages from the rounded-up kernel end to the top, reading then
// writing back each page's count after the setup states S_INIT_ROUND, S_INIT_OFFS.
// After reset a clearing pass zeroes the count memory, one entry per cycle, during
// which no request is accepted; configuration writes are taken at any time and
// should only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "refcounted_page_free_list_allocator_defines.svh"

module refcounted_page_free_list_allocator import rpfl_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  rpfl_req_if.sink           req,
  rpfl_rsp_if.source         rsp,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [APB_AW-1:0]  paddr,
  input  wire  [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // Sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR      = 8'b0000_0001,
    S_IDLE       = 8'b0000_0010,
    S_EXEC       = 8'b0000_0100,
    S_INIT_ROUND = 8'b0000_1000,
    S_INIT_OFFS  = 8'b0001_0000,
    S_INIT_RD    = 8'b0010_0000,
    S_INIT_WR    = 8'b0100_0000,
    S_INIT_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] kend_addr;

  // Control state.
  logic [CNT_W-1:0]  stack_count, stack_count_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  logic [IDX_W-1:0]  walk_idx, walk_idx_next;
  logic [IDX_W-1:0]  walk_last, walk_last_next;
  logic [WIDE_W-1:0] init_p, init_p_next;
  logic              init_ovf, init_ovf_next;
  logic              init_freed, init_freed_next;

  // Request captured at accept.
  req_kind_t         op_kind;
  logic              op_bad;
  logic              op_empty;
  logic [IDX_W-1:0]  op_idx;

  // Result register.
  logic              out_valid;
  status_t           out_status, out_status_next;
  logic [ADDR_W-1:0] out_alloc, out_alloc_next;
  logic              out_freed, out_freed_next;
  logic [REF_W-1:0]  out_count, out_count_next;
  logic              out_load;
  logic              out_free;

  // Memories and their ports.
  logic [REF_W-1:0]  ref_mem [NUM_PAGES];
  logic [IDX_W-1:0]  stack_mem [NUM_PAGES];
  logic              ref_we, ref_re;
  logic [IDX_W-1:0]  ref_waddr, ref_raddr;
  logic [REF_W-1:0]  ref_wdata, ref_rdata;
  logic              stack_we, stack_re;
  logic [IDX_W-1:0]  stack_waddr, stack_raddr, stack_rdata;

  // Request decode.
  req_kind_t         req_kind;
  logic              accept;
  logic [WIDE_W-1:0] req_diff;
  logic              req_in_range;
  logic              req_aligned;
  logic              req_above_kend;
  logic [IDX_W-1:0]  req_idx;
  logic              req_bad;

  // Release and increment arithmetic on the count read back.
  logic [IDX_W-1:0]  rel_idx;
  logic [REF_W-1:0]  rel_dec;
  logic              rel_zero;
  logic [REF_W-1:0]  inc_val;
  logic              stack_full;

  // Init start computation.
  logic [WIDE_W-1:0] init_d;
  logic [QIDX_W-1:0] init_q;
  logic [QIDX_W-1:0] init_last;

  // Configuration port: writes at the access phase, reads return the register.
  assign pready = 1'b1;

  always_comb begin
    case (cfg_reg_t'(paddr[CFG_SEL_BIT]))
      CFG_BASE: prdata = APB_DW'(base_addr);
      CFG_KEND: prdata = APB_DW'(kend_addr);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= BASE_RESET;
      kend_addr <= KEND_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_reg_t'(paddr[CFG_SEL_BIT]))
        CFG_BASE: base_addr <= pwdata[ADDR_W-1:0];
        CFG_KEND: kend_addr <= pwdata[ADDR_W-1:0];
        default:  ;
      endcase
    end
  end

  // Address checks for an incoming request.
  assign req_kind       = req_kind_t'(req.req_type);
  assign req.ready      = (state == S_IDLE);
  assign accept         = req.valid && req.ready;
  assign req_diff       = WIDE_W'(req.page_address) - WIDE_W'(base_addr);
  assign req_in_range   = !req_diff[WIDE_W-1] && (req_diff < SPAN);
  assign req_aligned    = (req.page_address[PAGE_SHIFT-1:0] == '0);
  assign req_above_kend = (req.page_address >= kend_addr);
  assign req_idx        = req_diff[PAGE_SHIFT +: IDX_W];

  always_comb begin
    case (req_kind)
      REQ_FREE:   req_bad = !(req_aligned && req_above_kend && req_in_range);
      REQ_INCREF: req_bad = !req_in_range;
      default:    req_bad = 1'b0;
    endcase
  end

  // Count update arithmetic: release shared by free and init, increment for incref.
  assign rel_idx    = (state == S_INIT_WR) ? walk_idx : op_idx;
  assign rel_dec    = (ref_rdata != '0) ? ref_rdata - REF_W'(1) : '0;
  assign rel_zero   = (rel_dec == '0);
  assign inc_val    = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + REF_W'(1);
  assign stack_full = (stack_count == STACK_FULL);

  // First page index of the init walk and the last one that fits below the top.
  assign init_d    = init_p - WIDE_W'(base_addr);
  assign init_q    = init_d[WIDE_W-1] ? '0 : init_d[WIDE_W-1:PAGE_SHIFT];
  assign init_last = (init_d[PAGE_SHIFT-1:0] != '0) ? QIDX_W'(NUM_PAGES - 2)
                                                    : QIDX_W'(NUM_PAGES - 1);

  assign out_free = !out_valid || rsp.ready;

  // Sequencer and read-modify-write control.
  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    clr_idx_next     = clr_idx;
    walk_idx_next    = walk_idx;
    walk_last_next   = walk_last;
    init_p_next      = init_p;
    init_ovf_next    = init_ovf;
    init_freed_next  = init_freed;

    ref_we      = 1'b0;
    ref_waddr   = rel_idx;
    ref_wdata   = '0;
    ref_re      = 1'b0;
    ref_raddr   = req_idx;
    stack_we    = 1'b0;
    stack_waddr = stack_count[IDX_W-1:0];
    stack_re    = 1'b0;
    stack_raddr = IDX_W'(stack_count - CNT_W'(1));

    out_load        = 1'b0;
    out_status_next = STS_OK;
    out_alloc_next  = '0;
    out_freed_next  = 1'b0;
    out_count_next  = '0;

    case (state)
      S_CLEAR: begin
        ref_we       = 1'b1;
        ref_waddr    = clr_idx;
        ref_wdata    = '0;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          ref_re   = (req_kind == REQ_FREE) || (req_kind == REQ_INCREF);
          stack_re = (req_kind == REQ_ALLOC);
          state_next = (req_kind == REQ_INIT) ? S_INIT_ROUND : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          case (op_kind)
            REQ_ALLOC: begin
              if (op_empty) begin
                out_status_next = STS_NO_PAGE;
              end else begin
                stack_count_next = stack_count - CNT_W'(1);
                ref_we           = 1'b1;
                ref_waddr        = stack_rdata;
                ref_wdata        = REF_W'(1);
                out_alloc_next   = base_addr +
                                   ADDR_W'({stack_rdata, {PAGE_SHIFT{1'b0}}});
                out_count_next   = REF_W'(1);
              end
            end
            REQ_FREE: begin
              if (op_bad) begin
                out_status_next = STS_BAD_ADDR;
              end else begin
                ref_we         = 1'b1;
                ref_wdata      = rel_dec;
                out_count_next = rel_dec;
                if (rel_zero) begin
                  if (stack_full) begin
                    out_status_next = STS_OVERFLOW;
                  end else begin
                    stack_we         = 1'b1;
                    stack_count_next = stack_count + CNT_W'(1);
                    out_freed_next   = 1'b1;
                  end
                end
              end
            end
            REQ_INCREF: begin
              if (op_bad) begin
                out_status_next = STS_BAD_ADDR;
              end else begin
                ref_we         = 1'b1;
                ref_wdata      = inc_val;
                out_count_next = inc_val;
              end
            end
            default: ;
          endcase
        end
      end

      S_INIT_ROUND: begin
        init_p_next     = (WIDE_W'(kend_addr) + PAGE_MASK) & ~PAGE_MASK;
        init_ovf_next   = 1'b0;
        init_freed_next = 1'b0;
        state_next      = S_INIT_OFFS;
      end

      S_INIT_OFFS: begin
        walk_idx_next  = init_q[IDX_W-1:0];
        walk_last_next = init_last[IDX_W-1:0];
        state_next     = (init_q > init_last) ? S_INIT_DONE : S_INIT_RD;
      end

      S_INIT_RD: begin
        ref_re     = 1'b1;
        ref_raddr  = walk_idx;
        state_next = S_INIT_WR;
      end

      S_INIT_WR: begin
        ref_we    = 1'b1;
        ref_wdata = rel_dec;
        if (rel_zero) begin
          if (stack_full) begin
            init_ovf_next = 1'b1;
          end else begin
            stack_we         = 1'b1;
            stack_count_next = stack_count + CNT_W'(1);
            init_freed_next  = 1'b1;
          end
        end
        walk_idx_next = walk_idx + IDX_W'(1);
        state_next    = (walk_idx == walk_last) ? S_INIT_DONE : S_INIT_RD;
      end

      S_INIT_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = init_ovf ? STS_OVERFLOW : STS_OK;
          out_freed_next  = init_freed;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      stack_count <= '0;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      clr_idx     <= clr_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    walk_idx   <= walk_idx_next;
    walk_last  <= walk_last_next;
    init_p     <= init_p_next;
    init_ovf   <= init_ovf_next;
    init_freed <= init_freed_next;
    if (accept) begin
      op_kind  <= req_kind;
      op_bad   <= req_bad;
      op_empty <= (stack_count == '0);
      op_idx   <= req_idx;
    end
    if (out_load) begin
      out_status <= out_status_next;
      out_alloc  <= out_alloc_next;
      out_freed  <= out_freed_next;
      out_count  <= out_count_next;
    end
  end

  // Reference count memory.
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (ref_re) begin
      ref_rdata <= ref_mem[ref_raddr];
    end
  end

  // Free stack memory.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= rel_idx;
    end
    if (stack_re) begin
      stack_rdata <= stack_mem[stack_raddr];
    end
  end

  // Result channel.
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.alloc_address = out_alloc;
  assign rsp.page_freed    = out_freed;
  assign rsp.ref_count     = out_count;

  // The stack never holds more pages than exist.
  `RPFL_ASSERT_NOW(a_count_bound, 1'b1, stack_count <= STACK_FULL)
  // A push only happens with room on the stack.
  `RPFL_ASSERT_NOW(a_push_room, stack_we, !stack_full)
  // A waiting result is never overwritten.
  `RPFL_ASSERT_NOW(a_no_overwrite, out_load, !out_valid || rsp.ready)
  // No request is taken before the count memory is cleared.
  `RPFL_ASSERT_NOW(a_clear_blocks, state == S_CLEAR, !req.ready)
  // Every accepted request leaves the idle state on the next cycle.
  `RPFL_ASSERT_NEXT(a_accept_leaves, accept, state != S_IDLE)

endmodule

`default_nettype wire
